@@ design/base64_decoder_top_macros.svh @@
// Assertion macros for the base64 decoder RTL.
`ifndef BASE64_DECODER_TOP_MACROS_SVH
`define BASE64_DECODER_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define B64D_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("b64d assertion failed");

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define B64D_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("b64d assertion failed");

`endif

@@ design/b64d_pkg.sv @@
// Shared types for the base64 decoder.
package b64d_pkg;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_LENGTH = 2'd1,
    ST_CHAR   = 2'd2,
    ST_PAD    = 2'd3
  } status_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       message_end;
    status_e    status;
    logic       run_last;
  } result_t;

  localparam int unsigned MaxResults = 3;

  // Results caused by one character; res[0] goes out first.
  typedef struct packed {
    logic [1:0]                 count;
    result_t [MaxResults-1:0]   res;
  } bundle_t;

endpackage

@@ design/base64_decoder_top.sv @@
// Top level of the streaming base64 decoder.
//
// Streaming base64 decoder for the standard alphabet (A-Z, a-z, 0-9, '+', '/',
// pad '='). Each input request carries one ASCII character in s_axis_tdata_i
// and s_axis_tlast_i marks the final character of a message. Every fourth
// character completes a group and yields three bytes; a pad in the last spot
// yields two bytes, and a pad in the second-to-last spot yields one byte and
// skips the one character after it. Bad length, bad character and bad padding
// set a sticky error (first one wins), after which no more bytes come out; the
// status is given only on the request flagged with m_axis_tlast_o, and bytes
// sent before an error must be dropped by the consumer. The final character
// always produces a result, with byte_valid low if it brings no byte.
// Rate: a character is decoded in the cycle it is accepted, and its results
// (zero to three) are loaded into a result register that drains one output
// request per cycle while the consumer is ready. A new character is accepted
// whenever that register is empty or its last result leaves in the same cycle,
// so characters with zero or one result stream at one per cycle when the
// consumer is ready; the first result is offered in the cycle after accept.
module base64_decoder_top
  import b64d_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [7:0] char_code
  input  logic       s_axis_tlast_i,   // last_char
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,   // [7:0] data_byte
  output logic       m_axis_tlast_o,   // message_end
  output logic [3:0] m_axis_tuser_o    // [0] byte_valid, [2:1] status, [3] run_last
);

  logic    accept;
  logic    free;
  bundle_t bundle;
  result_t res;

  assign s_axis_tready_o = free;
  assign accept          = s_axis_tvalid_i && free;

  b64d_decode u_decode (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .char_code_i (s_axis_tdata_i),
    .last_char_i (s_axis_tlast_i),
    .bundle_o    (bundle)
  );

  b64d_out_buf u_out_buf (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (accept),
    .bundle_i (bundle),
    .free_o   (free),
    .valid_o  (m_axis_tvalid_o),
    .ready_i  (m_axis_tready_i),
    .res_o    (res)
  );

  // zero data when no byte is carried, matching the empty end result
  assign m_axis_tdata_o = res.byte_valid ? res.data_byte : 8'h00;
  assign m_axis_tlast_o = res.message_end;
  assign m_axis_tuser_o = {res.run_last, logic'(res.status[1]), logic'(res.status[0]),
                           res.byte_valid};

endmodule

@@ design/b64d_decode.sv @@
// Character classification, group state and result bundle generation.
module b64d_decode
  import b64d_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [7:0] char_code_i,
  input  logic       last_char_i,
  output bundle_t    bundle_o
);

  typedef struct packed {
    logic       is_alpha;
    logic       is_pad;
    logic [5:0] val;
  } char_class_t;

  function automatic char_class_t classify(input logic [7:0] c);
    char_class_t r;
    r = '0;
    if (c inside {[8'h41:8'h5A]}) begin
      r.is_alpha = 1'b1;
      r.val      = 6'(c - 8'h41);
    end else if (c inside {[8'h61:8'h7A]}) begin
      r.is_alpha = 1'b1;
      r.val      = 6'(c - 8'h47);
    end else if (c inside {[8'h30:8'h39]}) begin
      r.is_alpha = 1'b1;
      r.val      = 6'(c + 8'h04);
    end else if (c == 8'h2B) begin
      r.is_alpha = 1'b1;
      r.val      = 6'h3E;
    end else if (c == 8'h2F) begin
      r.is_alpha = 1'b1;
      r.val      = 6'h3F;
    end else if (c == 8'h3D) begin
      r.is_pad = 1'b1;
    end
    return r;
  endfunction

  logic [17:0] acc_q, acc_d;
  logic [1:0]  pos_q, pos_d;
  status_e     err_q, err_d;
  logic        stop_q, stop_d;
  char_class_t cls;
  bundle_t     bun;
  logic [1:0]  tail;

  assign cls = classify(char_code_i);

  always_comb begin
    acc_d  = acc_q;
    pos_d  = pos_q;
    err_d  = err_q;
    stop_d = stop_q;
    bun    = '0;

    if (err_q == ST_OK) begin
      if (stop_q) begin
        if (!last_char_i) err_d = ST_PAD;
      end else if (last_char_i && pos_q != 2'd3) begin
        err_d = ST_LENGTH;
      end else if (cls.is_alpha) begin
        if (pos_q != 2'd3) begin
          acc_d = {acc_q[11:0], cls.val};
          pos_d = 2'(pos_q + 2'd1);
        end else begin
          bun.count             = 2'd3;
          bun.res[0].data_byte  = acc_q[17:10];
          bun.res[0].byte_valid = 1'b1;
          bun.res[1].data_byte  = acc_q[9:2];
          bun.res[1].byte_valid = 1'b1;
          bun.res[2].data_byte  = {acc_q[1:0], cls.val};
          bun.res[2].byte_valid = 1'b1;
          acc_d = '0;
          pos_d = '0;
        end
      end else if (cls.is_pad) begin
        if (pos_q == 2'd3) begin
          if (last_char_i) begin
            bun.count             = 2'd2;
            bun.res[0].data_byte  = acc_q[17:10];
            bun.res[0].byte_valid = 1'b1;
            bun.res[1].data_byte  = acc_q[9:2];
            bun.res[1].byte_valid = 1'b1;
          end else begin
            err_d = ST_PAD;
          end
        end else if (pos_q == 2'd2) begin
          // second-to-last pad: one byte, skip the next character
          bun.count             = 2'd1;
          bun.res[0].data_byte  = acc_q[11:4];
          bun.res[0].byte_valid = 1'b1;
          stop_d = 1'b1;
          pos_d  = 2'd3;
        end else begin
          err_d = ST_PAD;
        end
      end else begin
        err_d = ST_CHAR;
      end
    end

    if (last_char_i) begin
      if (bun.count == 2'd0) bun.count = 2'd1;
    end
    tail = 2'(bun.count - 2'd1);

    if (last_char_i) begin
      bun.res[tail].message_end = 1'b1;
      bun.res[tail].status      = err_d;
      acc_d  = '0;
      pos_d  = '0;
      err_d  = ST_OK;
      stop_d = 1'b0;
    end
    if (bun.count != 2'd0) bun.res[tail].run_last = 1'b1;
  end

  assign bundle_o = bun;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= '0;
      pos_q  <= '0;
      err_q  <= ST_OK;
      stop_q <= 1'b0;
    end else if (accept_i) begin
      acc_q  <= acc_d;
      pos_q  <= pos_d;
      err_q  <= err_d;
      stop_q <= stop_d;
    end
  end

endmodule

@@ design/b64d_out_buf.sv @@
// Result register for one bundle; sends its results one per cycle on ready_i.
`include "base64_decoder_top_macros.svh"

module b64d_out_buf
  import b64d_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    load_i,
  input  bundle_t bundle_i,
  output logic    free_o,
  output logic    valid_o,
  input  logic    ready_i,
  output result_t res_o
);

  result_t [MaxResults-1:0] res_q;
  logic [1:0] rem_q;
  logic [1:0] idx_q;
  logic       take;
  logic       load;

  assign valid_o = (rem_q != 2'd0);
  assign take    = valid_o && ready_i;
  assign free_o  = (rem_q == 2'd0) || (take && rem_q == 2'd1);
  assign load    = load_i && (bundle_i.count != 2'd0);
  assign res_o   = res_q[idx_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= '0;
      idx_q <= '0;
    end else if (load) begin
      rem_q <= bundle_i.count;
      idx_q <= '0;
    end else if (take) begin
      rem_q <= 2'(rem_q - 2'd1);
      idx_q <= 2'(idx_q + 2'd1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) res_q <= bundle_i.res;
  end

  // index never runs past the stored results
  `B64D_ASSERT_NOW(a_idx_in_range, valid_o, ({1'b0, idx_q} + {1'b0, rem_q}) <= 3'd3)
  // the final result of a bundle closes the run
  `B64D_ASSERT_NOW(a_tail_run_last, valid_o && rem_q == 2'd1, res_o.run_last)
  // a message end is always the last result of its character
  `B64D_ASSERT_NOW(a_end_is_tail, valid_o && res_o.message_end, rem_q == 2'd1)
  // a loaded bundle is offered next cycle
  `B64D_ASSERT_NEXT(a_load_shows, load, valid_o && idx_q == 2'd0)

endmodule

@@ verif/testbench.sv @@
// Self-checking testbench for the streaming base64 decoder.
`timescale 1ns / 1ps

module testbench;
  import b64d_pkg::*;

  localparam logic [7:0] PadChar = 8'h3D;
  localparam logic [6:0] PadSextet = 7'd64;
  localparam logic [6:0] BadSextet = 7'd65;

  typedef logic [7:0] char_q_t[$];

  // Tracks decoder state per message and holds the decoded bytes still owed.
  class decode_scoreboard;
    result_t     owed[$];
    logic [17:0] sextets;
    logic [1:0]  slot;
    status_e     sticky_err;
    logic        skip_one;
    int          failures;

    function new();
      failures = 0;
      clear_state();
    endfunction

    function void clear_state();
      sextets    = '0;
      slot       = '0;
      sticky_err = ST_OK;
      skip_one   = 1'b0;
    endfunction

    function logic [6:0] sextet_of(logic [7:0] c);
      if (c >= 8'h41 && c <= 8'h5A) return 7'(c - 8'h41);
      if (c >= 8'h61 && c <= 8'h7A) return 7'(c - 8'h47);
      if (c >= 8'h30 && c <= 8'h39) return 7'(c + 8'h04);
      if (c == 8'h2B) return 7'd62;
      if (c == 8'h2F) return 7'd63;
      if (c == PadChar) return PadSextet;
      return BadSextet;
    endfunction

    function result_t byte_result(logic [7:0] b);
      result_t r;
      r = '0;
      r.data_byte  = b;
      r.byte_valid = 1'b1;
      r.status     = ST_OK;
      return r;
    endfunction

    // Called for every accepted character.
    function void note_char(logic [7:0] c, logic last);
      result_t     outs[3];
      int          n;
      logic [6:0]  v;
      logic [23:0] w;
      n = 0;
      if (sticky_err == ST_OK) begin
        if (skip_one) begin
          // only one character may follow a second-to-last pad
          if (!last) sticky_err = ST_PAD;
        end else if (last && slot != 2'd3) begin
          sticky_err = ST_LENGTH;
        end else begin
          v = sextet_of(c);
          if (v < PadSextet) begin
            if (slot != 2'd3) begin
              sextets = {sextets[11:0], v[5:0]};
              slot++;
            end else begin
              w = {sextets, v[5:0]};
              outs[0] = byte_result(w[23:16]);
              outs[1] = byte_result(w[15:8]);
              outs[2] = byte_result(w[7:0]);
              n = 3;
              sextets = '0;
              slot    = '0;
            end
          end else if (v == PadSextet) begin
            if (slot == 2'd3) begin
              if (last) begin
                w = {sextets, 6'd0};
                outs[0] = byte_result(w[23:16]);
                outs[1] = byte_result(w[15:8]);
                n = 2;
              end else begin
                sticky_err = ST_PAD;
              end
            end else if (slot == 2'd2) begin
              outs[0] = byte_result(sextets[11:4]);
              n = 1;
              skip_one = 1'b1;
              slot = 2'd3;
            end else begin
              sticky_err = ST_PAD;
            end
          end else begin
            sticky_err = ST_CHAR;
          end
        end
      end
      if (last) begin
        if (n == 0) begin
          outs[0] = '0;
          n = 1;
        end
        outs[n-1].message_end = 1'b1;
        outs[n-1].status      = sticky_err;
        clear_state();
      end
      if (n > 0) outs[n-1].run_last = 1'b1;
      for (int i = 0; i < n; i++) owed = {owed, outs[i]};
    endfunction

    task report_mismatch(input string what);
      $display("MISMATCH at %0t ns: %s", $time, what);
      failures++;
    endtask

    // Called for every accepted output request. Data is zero without
    // byte_valid, status is zero off the message end.
    task check_result(input logic [7:0] data, input logic tlast, input logic [3:0] user);
      result_t e;
      if (owed.size() == 0) begin
        report_mismatch($sformatf("unexpected output data=%02h last=%b user=%h",
                                  data, tlast, user));
      end else begin
        e = owed.pop_front();
        if (user[0] !== e.byte_valid)
          report_mismatch($sformatf("byte_valid %b, want %b", user[0], e.byte_valid));
        if (data !== e.data_byte)
          report_mismatch($sformatf("data_byte %02h, want %02h", data, e.data_byte));
        if (tlast !== e.message_end)
          report_mismatch($sformatf("message_end %b, want %b", tlast, e.message_end));
        if (user[2:1] !== e.status)
          report_mismatch($sformatf("status %0d, want %0d", user[2:1], e.status));
        if (user[3] !== e.run_last)
          report_mismatch($sformatf("run_last %b, want %b", user[3], e.run_last));
      end
    endtask
  endclass

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       s_axis_tvalid_i = 1'b0;
  logic       s_axis_tready_o;
  logic [7:0] s_axis_tdata_i = '0;
  logic       s_axis_tlast_i = 1'b0;
  logic       m_axis_tvalid_o;
  logic       m_axis_tready_i = 1'b0;
  logic [7:0] m_axis_tdata_o;
  logic       m_axis_tlast_o;
  logic [3:0] m_axis_tuser_o;

  logic idle_on = 1'b1;
  decode_scoreboard sb = new();

  always #5 clk_i = ~clk_i;

  base64_decoder_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tlast_i (s_axis_tlast_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tlast_o (m_axis_tlast_o),
    .m_axis_tuser_o (m_axis_tuser_o)
  );

  // Consumer backpressure.
  always @(posedge clk_i) begin
    m_axis_tready_i <= !(idle_on && $urandom_range(99) < 38);
  end

  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid_i && s_axis_tready_o)
      sb.note_char(s_axis_tdata_i, s_axis_tlast_i);
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i)
      sb.check_result(m_axis_tdata_o, m_axis_tlast_o, m_axis_tuser_o);
  end

  function automatic logic [7:0] alpha_char();
    int k;
    k = $urandom_range(63);
    if (k < 26) return 8'(8'h41 + k);
    if (k < 52) return 8'(8'h61 + k - 26);
    if (k < 62) return 8'(8'h30 + k - 52);
    return (k == 62) ? 8'h2B : 8'h2F;
  endfunction

  task automatic send_message(input char_q_t msg);
    foreach (msg[i]) begin
      while (idle_on && $urandom_range(99) < 38) begin
        s_axis_tvalid_i <= 1'b0;
        @(posedge clk_i);
      end
      s_axis_tvalid_i <= 1'b1;
      s_axis_tdata_i  <= msg[i];
      s_axis_tlast_i  <= (i == msg.size() - 1);
      @(posedge clk_i);
      while (!s_axis_tready_o) @(posedge clk_i);
    end
  endtask

  task automatic send_text(input string s);
    char_q_t msg;
    for (int i = 0; i < s.len(); i++) msg = {msg, s[i]};
    send_message(msg);
  endtask

  // Hold the sender until all owed output has drained.
  task automatic wait_drained();
    s_axis_tvalid_i <= 1'b0;
    while (sb.owed.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Mostly well-formed messages, some with one defect, the rest noise.
  task automatic build_message(output char_q_t msg);
    int kind;
    int groups;
    int pads;
    int spot;
    msg = {};
    kind = $urandom_range(99);
    if (kind < 70) begin
      groups = $urandom_range(3, 1);
      pads   = $urandom_range(2);
      for (int i = 0; i < groups * 4; i++) msg = {msg, alpha_char()};
      if (pads == 1) begin
        msg[msg.size()-1] = PadChar;
      end else if (pads == 2) begin
        msg[msg.size()-2] = PadChar;
        // character after a second-to-last pad goes unchecked
        msg[msg.size()-1] = $urandom_range(1) ? PadChar : 8'($urandom);
      end
      if (kind >= 55) begin
        spot = $urandom_range(msg.size() - 1);
        case ($urandom_range(3))
          0: msg[spot] = 8'($urandom);
          1: msg[spot] = PadChar;
          2: msg.delete(spot);
          default: msg = {msg, alpha_char()};
        endcase
      end
    end else begin
      repeat ($urandom_range(9, 1)) begin
        case ($urandom_range(2))
          0: msg = {msg, 8'($urandom)};
          1: msg = {msg, alpha_char()};
          default: msg = {msg, PadChar};
        endcase
      end
    end
  endtask

  initial begin
    char_q_t msg;
    int sent;
    int msg_idx;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_text("+/09Zaz=");   // alphabet edges, full group, two-byte pad
    send_text("QQ=#");       // one-byte pad, trailing char ignored
    send_text("QQ=AB");      // runs on past the ignored char
    send_text("A");          // short length
    msg = '{8'h41, PadChar, 8'hFF};
    send_message(msg);       // pad in second slot wins over length
    msg = '{8'h41, 8'h42, 8'h00, 8'h44};
    send_message(msg);       // illegal character
    wait_drained();

    sent = 0;
    msg_idx = 0;
    while (sent < 95) begin
      idle_on = !(msg_idx >= 6 && msg_idx < 11);
      build_message(msg);
      send_message(msg);
      sent += msg.size();
      if (msg_idx == 14) wait_drained();
      msg_idx++;
    end
    idle_on = 1'b1;

    wait_drained();
    repeat (6) @(posedge clk_i);
    if (sb.failures == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #1000000;
    $display("Some tests failed");
    $finish;
  end

endmodule
